FILE: hdl/rxs_pkg.sv
// ----------------------------------------------------------------------------
// rxs_pkg
// Shared constants and types of the descending exchange sort block.
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam int RXS_CAPACITY   = 64;
  localparam int RXS_SCORE_BITS = 16;
  localparam int RXS_TAG_BITS   = 8;

  typedef enum logic [2:0] {
    S_LOAD,
    S_GRAB,
    S_SCAN,
    S_PUT,
    S_ERD,
    S_EWAIT
  } seq_state_t;

  typedef struct packed {
    logic load;
    logic last;
  } emit_ctl_t;

endpackage

FILE: hdl/rxs_stream_ifs.sv
// ----------------------------------------------------------------------------
// rxs_stream_ifs
// Valid/ready channels for input records and sorted results.
// ----------------------------------------------------------------------------
interface rxs_in_if #(
  parameter int SCORE_BITS = rxs_pkg::RXS_SCORE_BITS,
  parameter int TAG_BITS   = rxs_pkg::RXS_TAG_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] score;
  logic        [TAG_BITS-1:0]   tag;
  logic                         final_item;

  modport source (output valid, score, tag, final_item, input ready);
  modport sink   (input valid, score, tag, final_item, output ready);
endinterface

interface rxs_out_if #(
  parameter int SCORE_BITS = rxs_pkg::RXS_SCORE_BITS,
  parameter int TAG_BITS   = rxs_pkg::RXS_TAG_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [SCORE_BITS-1:0] sorted_score;
  logic        [TAG_BITS-1:0]   sorted_tag;
  logic                         end_of_list;

  modport source (output valid, sorted_score, sorted_tag, end_of_list, input ready);
  modport sink   (input valid, sorted_score, sorted_tag, end_of_list, output ready);
endinterface

FILE: hdl/rxs_ram.sv
// ----------------------------------------------------------------------------
// rxs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rxs_ram #(
  parameter int WIDTH = rxs_pkg::RXS_SCORE_BITS + rxs_pkg::RXS_TAG_BITS,
  parameter int DEPTH = rxs_pkg::RXS_CAPACITY,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/rxs_seq.sv
// ----------------------------------------------------------------------------
// rxs_seq
// Record loader and exchange sort sequencer around the record RAM.
// ----------------------------------------------------------------------------
module rxs_seq #(
  parameter int CAPACITY   = rxs_pkg::RXS_CAPACITY,
  parameter int SCORE_BITS = rxs_pkg::RXS_SCORE_BITS,
  parameter int TAG_BITS   = rxs_pkg::RXS_TAG_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SCORE_BITS-1:0] in_score,
  input  logic        [TAG_BITS-1:0]   in_tag,
  input  logic                         in_final,
  input  logic                         obuf_free,
  output rxs_pkg::emit_ctl_t           emit,
  output logic signed [SCORE_BITS-1:0] emit_score,
  output logic        [TAG_BITS-1:0]   emit_tag
);
  import rxs_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = SCORE_BITS + TAG_BITS;

  seq_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] outer_r, outer_nxt;
  logic [AW-1:0] inner_r, inner_nxt;
  logic [RW-1:0] held_r, held_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [RW-1:0] rd_data;

  logic                         full;
  logic                         accept;
  logic [CW-1:0]                cnt_inc;
  logic                         inner_more;
  logic                         outer_more;
  logic                         greater;
  logic signed [SCORE_BITS-1:0] rd_score;
  logic signed [SCORE_BITS-1:0] held_score;

  rxs_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full       = (cnt_r == CW'(CAPACITY));
  assign accept     = in_valid && (state_r == S_LOAD);
  assign cnt_inc    = full ? cnt_r : cnt_r + CW'(1);
  assign inner_more = (CW'(inner_r) + CW'(1)) < cnt_r;
  assign outer_more = (CW'(outer_r) + CW'(2)) < cnt_r;
  assign rd_score   = rd_data[RW-1:TAG_BITS];
  assign held_score = held_r[RW-1:TAG_BITS];
  assign greater    = rd_score > held_score;
  assign emit_score = rd_data[RW-1:TAG_BITS];
  assign emit_tag   = rd_data[TAG_BITS-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (accept && in_final) begin
          state_nxt = (cnt_inc < CW'(2)) ? S_ERD : S_GRAB;
        end
      end
      S_GRAB: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!inner_more) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        state_nxt = outer_more ? S_GRAB : S_ERD;
      end
      S_ERD: begin
        state_nxt = S_EWAIT;
      end
      S_EWAIT: begin
        if (obuf_free) begin
          state_nxt = inner_more ? S_ERD : S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    emit       = '0;
    wr_en      = 1'b0;
    wr_addr    = inner_r;
    wr_data    = held_r;
    rd_en      = 1'b0;
    rd_addr    = inner_r;
    cnt_nxt    = cnt_r;
    outer_nxt  = outer_r;
    inner_nxt  = inner_r;
    held_nxt   = held_r;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          wr_en   = !full;
          wr_addr = cnt_r[AW-1:0];
          wr_data = {in_score, in_tag};
          cnt_nxt = cnt_inc;
          if (in_final) begin
            outer_nxt = '0;
            inner_nxt = '0;
            rd_en     = 1'b1;
            rd_addr   = '0;
          end
        end
      end
      S_GRAB: begin
        held_nxt  = rd_data;
        rd_en     = 1'b1;
        rd_addr   = outer_r + AW'(1);
        inner_nxt = outer_r + AW'(1);
      end
      S_SCAN: begin
        if (greater) begin
          wr_en    = 1'b1;
          wr_addr  = inner_r;
          wr_data  = held_r;
          held_nxt = rd_data;
        end
        if (inner_more) begin
          rd_en     = 1'b1;
          rd_addr   = inner_r + AW'(1);
          inner_nxt = inner_r + AW'(1);
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = outer_r;
        wr_data = held_r;
        if (outer_more) begin
          outer_nxt = outer_r + AW'(1);
          rd_en     = 1'b1;
          rd_addr   = outer_r + AW'(1);
        end else begin
          inner_nxt = '0;
        end
      end
      S_ERD: begin
        rd_en   = 1'b1;
        rd_addr = inner_r;
      end
      S_EWAIT: begin
        if (obuf_free) begin
          emit.load = 1'b1;
          emit.last = !inner_more;
          if (inner_more) begin
            inner_nxt = inner_r + AW'(1);
          end else begin
            cnt_nxt   = '0;
            outer_nxt = '0;
            inner_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      outer_r <= '0;
      inner_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      outer_r <= outer_nxt;
      inner_r <= inner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

FILE: hdl/rxs_obuf.sv
// ----------------------------------------------------------------------------
// rxs_obuf
// Output register that holds one sorted record until the receiver takes it.
// ----------------------------------------------------------------------------
module rxs_obuf #(
  parameter int SCORE_BITS = rxs_pkg::RXS_SCORE_BITS,
  parameter int TAG_BITS   = rxs_pkg::RXS_TAG_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rxs_pkg::emit_ctl_t           emit,
  input  logic signed [SCORE_BITS-1:0] emit_score,
  input  logic        [TAG_BITS-1:0]   emit_tag,
  output logic                         obuf_free,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SCORE_BITS-1:0] out_score,
  output logic        [TAG_BITS-1:0]   out_tag,
  output logic                         out_last
);
  import rxs_pkg::*;

  logic                         valid_r, valid_nxt;
  logic signed [SCORE_BITS-1:0] score_r;
  logic        [TAG_BITS-1:0]   tag_r;
  logic                         last_r;

  assign obuf_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_score = score_r;
  assign out_tag   = tag_r;
  assign out_last  = last_r;

  always_comb begin
    valid_nxt = valid_r;
    if (emit.load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      score_r <= emit_score;
      tag_r   <= emit_tag;
      last_r  <= emit.last;
    end
  end

endmodule

FILE: hdl/record_exchange_sort_desc.sv
// ----------------------------------------------------------------------------
// record_exchange_sort_desc
// Collects scored records and returns them sorted by score, highest first.
// ----------------------------------------------------------------------------
// Records arrive on in_rec, one per transfer, and are written to a record
// RAM of CAPACITY entries. A record that arrives with the RAM full is dropped.
// The transfer that carries final_item starts an exchange sort of the stored
// list; in_rec stays not ready until the whole list has been handed out.
// For each position i the sort reads the entries after it one per cycle
// through the single RAM read port. The results then leave on out_rec, each
// record read from the RAM and loaded into the output register before the
// next one is read, the last one with end_of_list set.
// A register on out_rec holds each result until the receiver takes it; while
// the receiver stalls, the sequencer waits. After the last result is loaded
// into that register, in_rec is ready again. Reset is synchronous and active
// low; it empties the list and the output register. The RAM needs no clearing.
// ----------------------------------------------------------------------------
module record_exchange_sort_desc #(
  parameter int CAPACITY   = rxs_pkg::RXS_CAPACITY,
  parameter int SCORE_BITS = rxs_pkg::RXS_SCORE_BITS,
  parameter int TAG_BITS   = rxs_pkg::RXS_TAG_BITS
) (
  input logic       clk,
  input logic       rst_n,
  rxs_in_if.sink    in_rec,
  rxs_out_if.source out_rec
);
  import rxs_pkg::*;

  emit_ctl_t                    emit;
  logic signed [SCORE_BITS-1:0] emit_score;
  logic        [TAG_BITS-1:0]   emit_tag;
  logic                         obuf_free;

  rxs_seq #(
    .CAPACITY   (CAPACITY),
    .SCORE_BITS (SCORE_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_rec.valid),
    .in_ready   (in_rec.ready),
    .in_score   (in_rec.score),
    .in_tag     (in_rec.tag),
    .in_final   (in_rec.final_item),
    .obuf_free  (obuf_free),
    .emit       (emit),
    .emit_score (emit_score),
    .emit_tag   (emit_tag)
  );

  rxs_obuf #(
    .SCORE_BITS (SCORE_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .emit_score (emit_score),
    .emit_tag   (emit_tag),
    .obuf_free  (obuf_free),
    .out_valid  (out_rec.valid),
    .out_ready  (out_rec.ready),
    .out_score  (out_rec.sorted_score),
    .out_tag    (out_rec.sorted_tag),
    .out_last   (out_rec.end_of_list)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.load |-> obuf_free)
    else $error("Result loaded into a full output register.");

  a_no_load_while_loading: assert property (@(posedge clk) disable iff (!rst_n)
    in_rec.ready |-> !emit.load)
    else $error("Result emitted while records are being collected.");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.load && emit.last) |=> in_rec.ready)
    else $error("Input not ready after the last result of a list.");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (!out_rec.valid && in_rec.ready))
    else $error("Block not idle after reset.");

endmodule

FILE: verif/tb_record_exchange_sort_desc.sv
// ----------------------------------------------------------------------------
// tb_record_exchange_sort_desc
// Self-checking testbench for the descending exchange sort of scored records.
// ----------------------------------------------------------------------------
// Lists of records are offered on the input channel with random gaps. Each
// accepted record feeds a local model that gathers the list and sorts it with
// the same exchange order when the final record arrives. The sorted records
// are queued and compared in order with every result taken from the output
// channel, which stalls at random. Directed lists cover the score extremes,
// ties, presorted lists and single-record lists. Random lists cover short
// lists, a full store and records dropped past capacity.
// ----------------------------------------------------------------------------
module tb_record_exchange_sort_desc;
  import rxs_pkg::*;

  localparam int TIMEOUT_CYCLES = 300000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int STIM_ITEMS     = 260;

  typedef logic signed [RXS_SCORE_BITS-1:0] score_t;
  typedef logic [RXS_TAG_BITS-1:0]          tag_t;

  typedef struct {
    score_t score;
    tag_t   tag;
    logic   final_item;
  } in_record_t;

  typedef struct {
    score_t score;
    tag_t   tag;
  } record_t;

  typedef struct {
    score_t score;
    tag_t   tag;
    logic   end_of_list;
  } ranked_t;

  logic clk;
  logic rst_n;

  rxs_in_if  in_rec_if ();
  rxs_out_if out_rec_if ();

  record_exchange_sort_desc u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_rec  (in_rec_if),
    .out_rec (out_rec_if)
  );

  in_record_t pending_records[$];
  record_t    gathered_list[$];
  ranked_t    ranked_records[$];
  int         fail_count;
  int         stim_items;
  int         in_wait;
  int         in_burst;
  int         out_wait;
  int         out_burst;

  always #5 clk = ~clk;

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void absorb_record(score_t score, tag_t tag, logic last);
    record_t swap;
    ranked_t ranked;
    if (gathered_list.size() < RXS_CAPACITY) begin
      swap.score = score;
      swap.tag   = tag;
      gathered_list.push_back(swap);
    end
    if (last) begin
      for (int i = 0; i + 1 < gathered_list.size(); i++) begin
        for (int j = i + 1; j < gathered_list.size(); j++) begin
          if (gathered_list[j].score > gathered_list[i].score) begin
            swap             = gathered_list[i];
            gathered_list[i] = gathered_list[j];
            gathered_list[j] = swap;
          end
        end
      end
      for (int k = 0; k < gathered_list.size(); k++) begin
        ranked.score       = gathered_list[k].score;
        ranked.tag         = gathered_list[k].tag;
        ranked.end_of_list = (k == gathered_list.size() - 1);
        ranked_records.push_back(ranked);
      end
      gathered_list.delete();
    end
  endfunction

  task automatic add_record(input int score, input int tag, input bit last);
    in_record_t rec;
    rec.score      = score_t'(score);
    rec.tag        = tag_t'(tag);
    rec.final_item = last;
    pending_records.push_back(rec);
    stim_items++;
  endtask

  task automatic add_random_list(input int len);
    int mode;
    int score;
    mode = $urandom_range(0, 3);
    for (int k = 0; k < len; k++) begin
      case (mode)
        0: begin
          score = int'($urandom_range(0, 6)) - 3;
        end
        1: begin
          case ($urandom_range(0, 3))
            0: score = -32768;
            1: score = 32767;
            2: score = -1;
            default: score = 0;
          endcase
        end
        default: begin
          score = $urandom_range(0, 16'hFFFF);
        end
      endcase
      add_record(score, $urandom_range(0, 255), k == len - 1);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_rec_if.valid <= 1'b0;
      in_wait         <= 0;
    end else begin
      if (in_rec_if.valid && in_rec_if.ready) begin
        absorb_record(in_rec_if.score, in_rec_if.tag, in_rec_if.final_item);
      end
      if (!in_rec_if.valid || in_rec_if.ready) begin
        if (in_wait > 0) begin
          in_wait         <= in_wait - 1;
          in_rec_if.valid <= 1'b0;
        end else if (pending_records.size() > 0) begin
          in_rec_if.score      <= pending_records[0].score;
          in_rec_if.tag        <= pending_records[0].tag;
          in_rec_if.final_item <= pending_records[0].final_item;
          in_rec_if.valid      <= 1'b1;
          void'(pending_records.pop_front());
          in_wait <= draw_gap(in_burst);
        end else begin
          in_rec_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ranked_t want;
    int      gap;
    if (!rst_n) begin
      out_rec_if.ready <= 1'b0;
      out_wait         <= 0;
    end else if (out_rec_if.valid && out_rec_if.ready) begin
      if (ranked_records.size() == 0) begin
        $error("unexpected result: sorted_score %0d sorted_tag %0d end_of_list %0b",
               out_rec_if.sorted_score, out_rec_if.sorted_tag, out_rec_if.end_of_list);
        fail_count++;
      end else begin
        want = ranked_records.pop_front();
        if (out_rec_if.sorted_score !== want.score) begin
          $error("sorted_score: expected %0d, actual %0d", want.score,
                 out_rec_if.sorted_score);
          fail_count++;
        end
        if (out_rec_if.sorted_tag !== want.tag) begin
          $error("sorted_tag: expected %0d, actual %0d", want.tag, out_rec_if.sorted_tag);
          fail_count++;
        end
        if (out_rec_if.end_of_list !== want.end_of_list) begin
          $error("end_of_list: expected %0b, actual %0b", want.end_of_list,
                 out_rec_if.end_of_list);
          fail_count++;
        end
      end
      gap = draw_gap(out_burst);
      out_wait         <= gap;
      out_rec_if.ready <= (gap == 0);
    end else if (out_wait > 0) begin
      out_wait         <= out_wait - 1;
      out_rec_if.ready <= (out_wait == 1);
    end else begin
      out_rec_if.ready <= 1'b1;
    end
  end

  initial begin
    int list_no;
    int len;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_rec_if.valid      = 1'b0;
    in_rec_if.score      = '0;
    in_rec_if.tag        = '0;
    in_rec_if.final_item = 1'b0;
    out_rec_if.ready     = 1'b0;
    fail_count           = 0;
    stim_items           = 0;
    in_burst             = 0;
    out_burst            = 0;

    add_record(-32768, 0, 1);
    add_record(32767, 255, 1);

    add_record(0, 8'h01, 0);
    add_record(-1, 8'hAA, 0);
    add_record(1, 8'h55, 0);
    add_record(-32768, 8'h80, 0);
    add_record(32767, 8'h7F, 1);

    // Equal scores keep the order that the exchange swaps leave behind.
    add_record(7, 10, 0);
    add_record(7, 20, 0);
    add_record(-3, 30, 0);
    add_record(7, 40, 0);
    add_record(-3, 50, 0);
    add_record(7, 60, 1);

    add_record(100, 1, 0);
    add_record(50, 2, 0);
    add_record(0, 3, 0);
    add_record(-50, 4, 1);

    add_record(-5, 5, 0);
    add_record(-4, 6, 0);
    add_record(-3, 7, 0);
    add_record(-2, 8, 1);

    list_no = 0;
    while (stim_items < STIM_ITEMS) begin
      if (list_no == 1) begin
        len = RXS_CAPACITY + $urandom_range(1, 5);
      end else if (list_no == 5) begin
        len = RXS_CAPACITY;
      end else if ($urandom_range(0, 7) == 0) begin
        len = $urandom_range(11, 30);
      end else begin
        len = $urandom_range(1, 10);
      end
      add_random_list(len);
      list_no++;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_records.size() != 0 || in_rec_if.valid) @(posedge clk);
    while (ranked_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
